>>> hdl/wsfs_pkg.sv
// ----------------------------------------------------------------------------
// wsfs_pkg
// Shared types, register map and constants of the windowed sinusoid field
// source: configuration struct, side-band struct, Taylor coefficients.
// ----------------------------------------------------------------------------
package wsfs_pkg;

   // field component codes
   typedef enum logic [2:0] {
      KIND_DX = 3'd0,
      KIND_DY = 3'd1,
      KIND_DZ = 3'd2,
      KIND_BX = 3'd3,
      KIND_BY = 3'd4,
      KIND_BZ = 3'd5
   } kind_type;

   // register map, byte address = 4 * index
   typedef enum logic [2:0] {
      REG_AMP_X         = 3'd0,
      REG_AMP_Y         = 3'd1,
      REG_STEP_X_NORM   = 3'd2,
      REG_STEP_Y_NORM   = 3'd3,
      REG_CENTER_X_NORM = 3'd4,
      REG_CENTER_Y_NORM = 3'd5,
      REG_PULSE_STEP    = 3'd6,
      REG_CARRIER_STEP  = 3'd7
   } reg_index_type;

   localparam int CSR_ADDR_BITS = 5;

   typedef struct packed {
      logic [15:0] amp_x;
      logic [15:0] amp_y;
      logic [31:0] step_x_norm;
      logic [31:0] step_y_norm;
      logic [31:0] center_x_norm;
      logic [31:0] center_y_norm;
      logic [31:0] pulse_phase_step;
      logic [31:0] carrier_phase_step;
   } cfg_type;

   // per-request side band carried alongside the radius path
   typedef struct packed {
      logic        is_dx;
      logic        zero;
      logic [31:0] tphase;
      logic [31:0] cphase;
   } side_type;

   typedef struct packed {
      logic is_dx;
      logic zero;
   } tag_type;

   localparam int POS_BITS       = 17;
   localparam int R2_BITS        = 2 * POS_BITS;
   localparam int SQRT_STEPS     = POS_BITS;
   localparam int SQRT_PER_STAGE = 3;
   localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
   localparam int COS_STAGES     = 9;

   // 2*pi in Q3.30
   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

   // Horner coefficients, Q1.30, integer-truncated 1/n!
   function automatic logic [30:0] horner_coef(input logic sin_sel, input logic [2:0] idx);
      logic [30:0] c;
      c = 31'd0;
      case (idx)
         3'd0:    c = sin_sel ? 31'd2958      : 31'd26630;
         3'd1:    c = sin_sel ? 31'd213044    : 31'd1491308;
         3'd2:    c = sin_sel ? 31'd8947848   : 31'd44739242;
         3'd3:    c = sin_sel ? 31'd178956970 : 31'd536870912;
         3'd4:    c = 31'd1073741824;
         default: c = 31'd0;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/wsfs_delay.sv
// ----------------------------------------------------------------------------
// wsfs_delay
// Enabled shift line with a valid bit per stage, used to keep side-band data
// aligned with the square root and cosine pipelines.
// ----------------------------------------------------------------------------
module wsfs_delay #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= DEPTH'({valid_ff, in_valid});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

>>> hdl/wsfs_front.sv
// ----------------------------------------------------------------------------
// wsfs_front
// Position and phase front end: scales cell indices into normalized
// positions, range checks them, forms r^2 and the pulse / carrier phases.
// Four register stages.
// ----------------------------------------------------------------------------
module wsfs_front #(
   parameter int INDEX_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2:0]            kind,
   input  logic [15:0]           cell_x,
   input  logic [15:0]           cell_y,
   input  logic [31:0]           time_step,
   input  wsfs_pkg::cfg_type     cfg,
   output logic                  out_valid,
   output wsfs_pkg::side_type    out_side,
   output logic [wsfs_pkg::R2_BITS-1:0] out_r2
);

   localparam int IXW = (INDEX_BITS < 16) ? INDEX_BITS : 16;
   localparam int MW  = IXW + 1;
   localparam int PW  = MW + 32;
   localparam int XW  = PW + 2;
   localparam int PB  = wsfs_pkg::POS_BITS;
   localparam int RB  = wsfs_pkg::R2_BITS;

   logic [3:0] valid_ff;

   // stage 1
   logic [PW-1:0] px1_ff, py1_ff;
   logic [63:0]   tprod1_ff;
   logic [31:0]   cph1_ff;
   logic          active1_ff, isdx1_ff;
   logic [MW-1:0] mx_in, my_in;

   // stage 2
   logic [PB-1:0]      ax2_ff, ay2_ff;
   wsfs_pkg::side_type side2_ff, side2_in;
   logic signed [XW-1:0] cxe, cye, xs_in, ys_in;
   logic [XW-1:0]        axw, ayw;

   // stage 3
   logic [RB-1:0]      sqx3_ff, sqy3_ff;
   wsfs_pkg::side_type side3_ff;

   // stage 4
   logic [RB-1:0]      r2_4_ff;
   wsfs_pkg::side_type side4_ff, side4_in;
   logic [RB:0]        r2sum;

   // doubled position with the half-cell offset on the other axis
   assign mx_in = {cell_x[IXW-1:0], kind == wsfs_pkg::KIND_DY};
   assign my_in = {cell_y[IXW-1:0], kind == wsfs_pkg::KIND_DX};

   always_comb begin
      cxe   = {{(XW-33){cfg.center_x_norm[31]}}, cfg.center_x_norm, 1'b0};
      cye   = {{(XW-33){cfg.center_y_norm[31]}}, cfg.center_y_norm, 1'b0};
      xs_in = $signed({2'b00, px1_ff}) - cxe;
      ys_in = $signed({2'b00, py1_ff}) - cye;
      axw   = xs_in[XW-1] ? XW'(~xs_in + 1'b1) : XW'(xs_in);
      ayw   = ys_in[XW-1] ? XW'(~ys_in + 1'b1) : XW'(ys_in);
      side2_in.is_dx  = isdx1_ff;
      side2_in.zero   = !active1_ff || (|axw[XW-1:PB]) || (|ayw[XW-1:PB])
                        || (|tprod1_ff[63:32]);
      side2_in.tphase = tprod1_ff[31:0];
      side2_in.cphase = cph1_ff;
   end

   always_comb begin
      r2sum         = {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
      side4_in      = side3_ff;
      side4_in.zero = side3_ff.zero || r2sum[RB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px1_ff     <= PW'(mx_in) * PW'(cfg.step_x_norm);
         py1_ff     <= PW'(my_in) * PW'(cfg.step_y_norm);
         tprod1_ff  <= 64'(time_step) * 64'(cfg.pulse_phase_step);
         cph1_ff    <= time_step * cfg.carrier_phase_step;
         active1_ff <= (kind == wsfs_pkg::KIND_DX) || (kind == wsfs_pkg::KIND_DY);
         isdx1_ff   <= (kind == wsfs_pkg::KIND_DX);

         ax2_ff   <= axw[PB-1:0];
         ay2_ff   <= ayw[PB-1:0];
         side2_ff <= side2_in;

         sqx3_ff  <= RB'(ax2_ff) * RB'(ax2_ff);
         sqy3_ff  <= RB'(ay2_ff) * RB'(ay2_ff);
         side3_ff <= side2_ff;

         r2_4_ff  <= r2sum[RB-1:0];
         side4_ff <= side4_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_side  = side4_ff;
   assign out_r2    = r2_4_ff;

endmodule

>>> hdl/wsfs_isqrt.sv
// ----------------------------------------------------------------------------
// wsfs_isqrt
// Pipelined digit-by-digit integer square root, floor(sqrt(radicand)).
// Three root bits are resolved per register stage, two in the last one.
// ----------------------------------------------------------------------------
module wsfs_isqrt (
   input  logic                             clock,
   input  logic                             en,
   input  logic [wsfs_pkg::R2_BITS-1:0]     radicand,
   output logic [wsfs_pkg::POS_BITS-1:0]    root
);

   localparam int NB  = wsfs_pkg::R2_BITS;
   localparam int RB  = wsfs_pkg::POS_BITS;
   localparam int WB  = RB + 4;
   localparam int NST = wsfs_pkg::SQRT_STAGES;
   localparam int PER = wsfs_pkg::SQRT_PER_STAGE;

   logic [WB-1:0] rem_ff  [NST];
   logic [RB-1:0] root_ff [NST];
   logic [NB-1:0] rad_ff  [NST];

   for (genvar s = 0; s < NST; s++) begin : g_stage
      logic [WB-1:0] rem_w, trial;
      logic [RB-1:0] root_w;
      logic [NB-1:0] rad_w;

      always_comb begin
         if (s == 0) begin
            rem_w  = '0;
            root_w = '0;
            rad_w  = radicand;
         end else begin
            rem_w  = rem_ff[(s == 0) ? 0 : s-1];
            root_w = root_ff[(s == 0) ? 0 : s-1];
            rad_w  = rad_ff[(s == 0) ? 0 : s-1];
         end
         trial = '0;
         for (int j = 0; j < PER; j++) begin
            if (s * PER + j < wsfs_pkg::SQRT_STEPS) begin
               rem_w = {rem_w[WB-3:0], rad_w[NB-1:NB-2]};
               rad_w = {rad_w[NB-3:0], 2'b00};
               trial = WB'({root_w, 2'b01});
               if (rem_w >= trial) begin
                  rem_w  = rem_w - trial;
                  root_w = {root_w[RB-2:0], 1'b1};
               end else begin
                  root_w = {root_w[RB-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_w;
            root_ff[s] <= root_w;
            rad_ff[s]  <= rad_w;
         end
      end
   end

   assign root = root_ff[NST-1];

endmodule

>>> hdl/wsfs_cos.sv
// ----------------------------------------------------------------------------
// wsfs_cos
// Pipelined cosine of a 32-bit turn fraction: octant fold, turn-to-radian
// scale, Horner evaluation of the cos or sin series in Q1.30, then rounding
// and saturation to signed Q1.(COS_BITS-1). Nine register stages.
// ----------------------------------------------------------------------------
module wsfs_cos #(
   parameter int COS_BITS = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [31:0]                phase,
   output logic signed [COS_BITS-1:0] cos_value
);

   localparam int F = COS_BITS - 1;
   localparam logic [F+1:0] LIM = (F+2)'((64'd1 << F) - 64'd1);

   logic        neg_ff [1:8];
   logic        sel_ff [1:8];
   logic [29:0] pf1_ff;
   logic [29:0] x_ff   [2:7];
   logic [29:0] xsq_ff [3:6];
   logic [30:0] t_ff   [4:7];
   logic [30:0] v_ff;
   logic [COS_BITS-1:0] cos_ff;

   logic [31:0] pa, pb, pf;
   logic        neg_in, sel_in;
   logic [62:0] rad_prod;
   logic [59:0] sq_prod;
   logic [60:0] fin_prod;
   logic [30:0] v_in;
   logic [31:0] rsum;
   logic [F+1:0] cw;
   logic [F-1:0] cmag;
   logic [COS_BITS-1:0] cpos, cos_in;

   // fold to [0, 1/8] turn
   always_comb begin
      pa     = phase[31] ? (32'd0 - phase) : phase;
      neg_in = pa > 32'h4000_0000;
      pb     = neg_in ? (32'h8000_0000 - pa) : pa;
      sel_in = pb > 32'h2000_0000;
      pf     = sel_in ? (32'h4000_0000 - pb) : pb;
   end

   assign rad_prod = 63'(pf1_ff) * 63'(wsfs_pkg::TWO_PI_Q30);
   assign sq_prod  = 60'(x_ff[2]) * 60'(x_ff[2]);

   // Horner steps: t = C[k+1] - x^2 * t
   for (genvar h = 0; h < 4; h++) begin : g_horner
      logic [30:0] t_prev, t_new;
      logic [60:0] hprod;
      always_comb begin
         t_prev = (h == 0) ? wsfs_pkg::horner_coef(sel_ff[3], 3'd0)
                           : t_ff[(h == 0) ? 4 : h+3];
         hprod  = 61'(xsq_ff[h+3]) * 61'(t_prev);
         t_new  = wsfs_pkg::horner_coef(sel_ff[h+3], 3'(h+1)) - hprod[60:30];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            t_ff[h+4] <= t_new;
         end
      end
   end

   // sin needs a last multiply by x
   always_comb begin
      fin_prod = 61'(x_ff[7]) * 61'(t_ff[7]);
      v_in     = sel_ff[7] ? fin_prod[60:30] : t_ff[7];
   end

   // round half up, saturate, apply sign
   always_comb begin
      rsum   = {1'b0, v_ff} + (32'd1 << (29 - F));
      cw     = rsum[31:30-F];
      cmag   = (cw > LIM) ? LIM[F-1:0] : cw[F-1:0];
      cpos   = {1'b0, cmag};
      cos_in = neg_ff[8] ? (~cpos + 1'b1) : cpos;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pf1_ff    <= pf[29:0];
         neg_ff[1] <= neg_in;
         sel_ff[1] <= sel_in;
         for (int i = 2; i <= 8; i++) begin
            neg_ff[i] <= neg_ff[i-1];
            sel_ff[i] <= sel_ff[i-1];
         end
         x_ff[2] <= rad_prod[61:32];
         for (int i = 3; i <= 7; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         xsq_ff[3] <= sq_prod[59:30];
         for (int i = 4; i <= 6; i++) begin
            xsq_ff[i] <= xsq_ff[i-1];
         end
         v_ff   <= v_in;
         cos_ff <= cos_in;
      end
   end

   assign cos_value = $signed(cos_ff);

endmodule

>>> hdl/windowed_sinusoid_field_source.sv
// ----------------------------------------------------------------------------
// windowed_sinusoid_field_source
// Source value of a raised-cosine windowed sinusoid at one grid cell and time
// step, for the Dx and Dy components; other components give zero.
//
//   channel  prefix  dir  payload
//   request  req_    in   kind, cell_x, cell_y, time_step
//   response rsp_    out  source_value
//   config   csr_    in   APB write/read, 8 registers at 4*i (amp_x/amp_y 16 bits)
//
// One request per cycle unless the output buffer is full; stages to rsp_valid:
// front end 4, square root 6, cosine 9, envelope product 3, output buffer 1.
// The pipeline stalls as a whole only when the 2-entry output buffer is full.
// Synchronous active-high reset clears valid bits and configuration registers.
// ----------------------------------------------------------------------------
module windowed_sinusoid_field_source #(
   parameter int INDEX_BITS = 16,
   parameter int COS_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_cell_x,
   input  logic [15:0] req_cell_y,
   input  logic [31:0] req_time_step,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_source_value,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [wsfs_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int F   = COS_BITS - 1;
   localparam int SHR = (F >= 16) ? F - 16 : 0;
   localparam int SHL = (F < 16) ? 16 - F : 0;

   wsfs_pkg::cfg_type       cfg_ff;
   wsfs_pkg::reg_index_type csr_idx;

   logic en;

   // front end
   logic                 fr_valid;
   wsfs_pkg::side_type   fr_side;
   logic [wsfs_pkg::R2_BITS-1:0]  fr_r2;

   // after square root
   logic                 sq_valid;
   wsfs_pkg::side_type   sq_side;
   logic [wsfs_pkg::POS_BITS-1:0] sq_root;
   logic [31:0]          rphase;

   // after cosines
   logic                 cs_valid;
   wsfs_pkg::tag_type    cs_tag_in, cs_tag;
   logic signed [COS_BITS-1:0] cr, ct, cc;

   // envelope product stages
   logic [2:0]  bvalid_ff;
   logic [F-1:0] m1_ff, ccmag1_ff, p2_ff;
   logic        cneg1_ff, cneg2_ff;
   wsfs_pkg::tag_type tag1_ff, tag2_ff;
   logic [31:0] res3_ff, res3_in;
   logic [F+1:0] one_f, ersum, etsum;
   logic [F-1:0] er, et, ccmag_in;
   logic [2*F-1:0] mprod, pprod;
   logic [COS_BITS-1:0] ccneg;
   logic [15:0] amp, amag;
   logic [F+15:0] mag_full;
   logic [47:0] mag_ext;
   logic [31:0] mag32;

   // output buffer
   logic        head_valid_ff, tail_valid_ff;
   logic [31:0] head_ff, tail_ff;
   logic        push, pop;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_idx    = wsfs_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            wsfs_pkg::REG_AMP_X:         cfg_ff.amp_x <= csr_pwdata[15:0];
            wsfs_pkg::REG_AMP_Y:         cfg_ff.amp_y <= csr_pwdata[15:0];
            wsfs_pkg::REG_STEP_X_NORM:   cfg_ff.step_x_norm <= csr_pwdata;
            wsfs_pkg::REG_STEP_Y_NORM:   cfg_ff.step_y_norm <= csr_pwdata;
            wsfs_pkg::REG_CENTER_X_NORM: cfg_ff.center_x_norm <= csr_pwdata;
            wsfs_pkg::REG_CENTER_Y_NORM: cfg_ff.center_y_norm <= csr_pwdata;
            wsfs_pkg::REG_PULSE_STEP:    cfg_ff.pulse_phase_step <= csr_pwdata;
            wsfs_pkg::REG_CARRIER_STEP:  cfg_ff.carrier_phase_step <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wsfs_pkg::REG_AMP_X:         csr_prdata = {16'd0, cfg_ff.amp_x};
         wsfs_pkg::REG_AMP_Y:         csr_prdata = {16'd0, cfg_ff.amp_y};
         wsfs_pkg::REG_STEP_X_NORM:   csr_prdata = cfg_ff.step_x_norm;
         wsfs_pkg::REG_STEP_Y_NORM:   csr_prdata = cfg_ff.step_y_norm;
         wsfs_pkg::REG_CENTER_X_NORM: csr_prdata = cfg_ff.center_x_norm;
         wsfs_pkg::REG_CENTER_Y_NORM: csr_prdata = cfg_ff.center_y_norm;
         wsfs_pkg::REG_PULSE_STEP:    csr_prdata = cfg_ff.pulse_phase_step;
         wsfs_pkg::REG_CARRIER_STEP:  csr_prdata = cfg_ff.carrier_phase_step;
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // --------------------------------------------------------------- pipeline
   // whole pipe advances unless the output buffer is full
   assign en        = !tail_valid_ff;
   assign req_ready = en;

   wsfs_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .kind      (req_kind),
      .cell_x    (req_cell_x),
      .cell_y    (req_cell_y),
      .time_step (req_time_step),
      .cfg       (cfg_ff),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_r2    (fr_r2)
   );

   wsfs_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (fr_r2),
      .root     (sq_root)
   );

   wsfs_delay #(
      .WIDTH ($bits(wsfs_pkg::side_type)),
      .DEPTH (wsfs_pkg::SQRT_STAGES)
   ) u_side_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_data   (fr_side),
      .out_valid (sq_valid),
      .out_data  (sq_side)
   );

   // radial phase is r/2 turns
   assign rphase = {1'b0, sq_root, 14'd0};

   wsfs_cos #(.COS_BITS(COS_BITS)) u_cos_r (
      .clock (clock), .en (en), .phase (rphase), .cos_value (cr)
   );

   wsfs_cos #(.COS_BITS(COS_BITS)) u_cos_t (
      .clock (clock), .en (en), .phase (sq_side.tphase), .cos_value (ct)
   );

   wsfs_cos #(.COS_BITS(COS_BITS)) u_cos_c (
      .clock (clock), .en (en), .phase (sq_side.cphase), .cos_value (cc)
   );

   assign cs_tag_in.is_dx = sq_side.is_dx;
   assign cs_tag_in.zero  = sq_side.zero;

   wsfs_delay #(
      .WIDTH ($bits(wsfs_pkg::tag_type)),
      .DEPTH (wsfs_pkg::COS_STAGES)
   ) u_tag_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_data   (cs_tag_in),
      .out_valid (cs_valid),
      .out_data  (cs_tag)
   );

   // envelopes: er = (1 + cr)/2, et = (1 - ct)/2
   always_comb begin
      one_f    = (F+2)'(64'd1 << F);
      ersum    = one_f + {cr[F], cr};
      etsum    = one_f - {ct[F], ct};
      er       = ersum[F:1];
      et       = etsum[F:1];
      mprod    = (2*F)'(er) * (2*F)'(et);
      ccneg    = ~cc + 1'b1;
      ccmag_in = cc[F] ? ccneg[F-1:0] : cc[F-1:0];
      pprod    = (2*F)'(m1_ff) * (2*F)'(ccmag1_ff);
   end

   always_comb begin
      amp      = tag2_ff.is_dx ? cfg_ff.amp_x : cfg_ff.amp_y;
      amag     = amp[15] ? (~amp + 16'd1) : amp;
      mag_full = (F+16)'(p2_ff) * (F+16)'(amag);
      mag_ext  = 48'(mag_full);
      mag32    = 32'((mag_ext >> SHR) << SHL);
      if (tag2_ff.zero) begin
         res3_in = 32'd0;
      end else if (amp[15] ^ cneg2_ff) begin
         res3_in = 32'd0 - mag32;
      end else begin
         res3_in = mag32;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= '0;
      end else if (en) begin
         bvalid_ff <= {bvalid_ff[1:0], cs_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff     <= mprod[2*F-1:F];
         ccmag1_ff <= ccmag_in;
         cneg1_ff  <= cc[F];
         tag1_ff   <= cs_tag;
         p2_ff     <= pprod[2*F-1:F];
         cneg2_ff  <= cneg1_ff;
         tag2_ff   <= tag1_ff;
         res3_ff   <= res3_in;
      end
   end

   // ---------------------------------------------------------- output buffer
   assign push = en && bvalid_ff[2];
   assign pop  = rsp_ready && head_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            head_valid_ff <= tail_valid_ff || push;
            tail_valid_ff <= 1'b0;
         end else if (push) begin
            head_valid_ff <= 1'b1;
            tail_valid_ff <= head_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         head_ff <= tail_valid_ff ? tail_ff : res3_ff;
      end else if (push) begin
         if (head_valid_ff) begin
            tail_ff <= res3_ff;
         end else begin
            head_ff <= res3_ff;
         end
      end
   end

   assign rsp_valid        = head_valid_ff;
   assign rsp_source_value = head_ff;

   // ------------------------------------------------------------- assertions
   a_tail_needs_head : assert property (@(posedge clock) disable iff (reset)
      tail_valid_ff |-> head_valid_ff)
      else $error("output buffer tail holds data with empty head");

   a_tail_fill_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(tail_valid_ff) |-> $past(head_valid_ff && !rsp_ready))
      else $error("tail filled while head was draining");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      (tail_valid_ff && !rsp_ready) |=> (tail_valid_ff && $stable(tail_ff)))
      else $error("full output buffer changed without a pop");

endmodule

>>> verif/windowed_sinusoid_field_source_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_sinusoid_field_source_tb
// Drives random and directed field-source requests through the valid/ready
// request channel, programs the registers over APB between phases, and
// checks every response against a fixed-point source-value predictor.
// ----------------------------------------------------------------------------
module windowed_sinusoid_field_source_tb;

   localparam int IDX_BITS  = 16;
   localparam int CFRAC     = 15;
   localparam longint Q30   = 64'd1 << 30;
   localparam int LATENCY   = 23;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] cell_x;
      logic [15:0] cell_y;
      logic [31:0] time_step;
   } src_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [15:0] req_cell_x = '0;
   logic [15:0] req_cell_y = '0;
   logic [31:0] req_time_step = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_source_value;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [wsfs_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   windowed_sinusoid_field_source dut (.*);

   always #2 clock = ~clock;

   wsfs_pkg::cfg_type model_cfg;
   src_req_type pending_reqs[$];
   logic [31:0] expected_values[$];
   int          fail_count = 0;
   int          drv_wait = 0;
   int          next_wait = 0;
   int          mon_wait = 0;
   int          hold_off = 0;
   bit          idle_enable = 1'b1;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned series_cos(longint unsigned x);
      longint unsigned x2, t;
      x2 = (x * x) >> 30;
      t = Q30 / 40320;
      t = Q30 / 720 - ((x2 * t) >> 30);
      t = Q30 / 24 - ((x2 * t) >> 30);
      t = Q30 / 2 - ((x2 * t) >> 30);
      return Q30 - ((x2 * t) >> 30);
   endfunction

   function automatic longint unsigned series_sin(longint unsigned x);
      longint unsigned x2, t;
      x2 = (x * x) >> 30;
      t = Q30 / 362880;
      t = Q30 / 5040 - ((x2 * t) >> 30);
      t = Q30 / 120 - ((x2 * t) >> 30);
      t = Q30 / 6 - ((x2 * t) >> 30);
      t = Q30 - ((x2 * t) >> 30);
      return (x * t) >> 30;
   endfunction

   // cosine of a turn fraction, Q1.15, saturated
   function automatic longint cos_of_turn(logic [31:0] p);
      bit neg;
      longint unsigned v, c, rad;
      neg = 1'b0;
      if (p[31]) p = 32'd0 - p;
      if (p > 32'h4000_0000) begin
         neg = 1'b1;
         p = 32'h8000_0000 - p;
      end
      if (p <= 32'h2000_0000) begin
         rad = (longint'(p) * 64'd6746518852) >> 32;
         v = series_cos(rad);
      end else begin
         rad = (longint'(32'h4000_0000 - p) * 64'd6746518852) >> 32;
         v = series_sin(rad);
      end
      c = (v + (64'd1 << (29 - CFRAC))) >> (30 - CFRAC);
      if (c > (64'd1 << CFRAC) - 1) c = (64'd1 << CFRAC) - 1;
      return neg ? -longint'(c) : longint'(c);
   endfunction

   function automatic logic [31:0] predict_source(src_req_type r);
      longint amp, xs, ys, cr, ct, cc;
      longint unsigned cx, cy, ts, ax, ay, r2, rr, tprod, er, et, m, p, mag;
      bit neg;
      if (r.kind != wsfs_pkg::KIND_DX && r.kind != wsfs_pkg::KIND_DY) return 32'd0;
      cx = r.cell_x & ((64'd1 << IDX_BITS) - 1);
      cy = r.cell_y & ((64'd1 << IDX_BITS) - 1);
      ts = r.time_step;
      amp = (r.kind == wsfs_pkg::KIND_DX) ? longint'($signed(model_cfg.amp_x))
                                          : longint'($signed(model_cfg.amp_y));
      xs = longint'((2 * cx + (r.kind == wsfs_pkg::KIND_DY)) * model_cfg.step_x_norm)
           - 2 * longint'($signed(model_cfg.center_x_norm));
      ys = longint'((2 * cy + (r.kind == wsfs_pkg::KIND_DX)) * model_cfg.step_y_norm)
           - 2 * longint'($signed(model_cfg.center_y_norm));
      ax = xs < 0 ? -xs : xs;
      ay = ys < 0 ? -ys : ys;
      if (ax >= (64'd1 << 17) || ay >= (64'd1 << 17)) return 32'd0;
      r2 = ax * ax + ay * ay;
      if (r2 >= (64'd1 << 34)) return 32'd0;
      rr = int_sqrt(r2);
      cr = cos_of_turn(32'(rr << 14));
      er = longint'((64'sd1 << CFRAC) + cr) >>> 1;
      tprod = ts * model_cfg.pulse_phase_step;
      if (tprod >= (64'd1 << 32)) return 32'd0;
      ct = cos_of_turn(tprod[31:0]);
      et = longint'((64'sd1 << CFRAC) - ct) >>> 1;
      cc = cos_of_turn(32'(ts * model_cfg.carrier_phase_step));
      m = (er * et) >> CFRAC;
      p = (m * longint'(cc < 0 ? -cc : cc)) >> CFRAC;
      mag = p * longint'(amp < 0 ? -amp : amp);
      mag <<= (16 - CFRAC);
      neg = (amp < 0) != (cc < 0);
      return neg ? 32'(64'd0 - mag) : mag[31:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic csr_write(input wsfs_pkg::reg_index_type idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= wsfs_pkg::CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         wsfs_pkg::REG_AMP_X:         model_cfg.amp_x = val[15:0];
         wsfs_pkg::REG_AMP_Y:         model_cfg.amp_y = val[15:0];
         wsfs_pkg::REG_STEP_X_NORM:   model_cfg.step_x_norm = val;
         wsfs_pkg::REG_STEP_Y_NORM:   model_cfg.step_y_norm = val;
         wsfs_pkg::REG_CENTER_X_NORM: model_cfg.center_x_norm = val;
         wsfs_pkg::REG_CENTER_Y_NORM: model_cfg.center_y_norm = val;
         wsfs_pkg::REG_PULSE_STEP:    model_cfg.pulse_phase_step = val;
         default:                     model_cfg.carrier_phase_step = val;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_values.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // program all registers with one of four settings
   task automatic program_setting(input int mode);
      logic [31:0] sx, sy;
      case (mode)
         0: begin sx = 32'h0000_2000; sy = 32'h0000_2000; end
         1: begin sx = 32'h0000_0400; sy = 32'h0000_0800; end
         2: begin sx = 32'hFFFF_FFFF; sy = 32'h0000_0000; end
         default: begin
            sx = $urandom_range(32'h100, 32'h8000);
            sy = $urandom_range(32'h100, 32'h8000);
         end
      endcase
      csr_write(wsfs_pkg::REG_AMP_X,
                mode == 0 ? 32'h7FFF : mode == 1 ? 32'hFFFF_8000 : $urandom);
      csr_write(wsfs_pkg::REG_AMP_Y,
                mode == 0 ? 32'hFFFF_8000 : mode == 1 ? 32'h7FFF : $urandom);
      csr_write(wsfs_pkg::REG_STEP_X_NORM, sx);
      csr_write(wsfs_pkg::REG_STEP_Y_NORM, sy);
      csr_write(wsfs_pkg::REG_CENTER_X_NORM, mode == 2 ? 32'h8000_0000 : (sx * 8) >> 1);
      csr_write(wsfs_pkg::REG_CENTER_Y_NORM, mode == 2 ? 32'h7FFF_FFFF : (sy * 8) >> 1);
      csr_write(wsfs_pkg::REG_PULSE_STEP,
                mode == 2 ? 32'hFFFF_FFFF : $urandom_range(32'h100_0000, 1));
      csr_write(wsfs_pkg::REG_CARRIER_STEP, mode == 2 ? 32'h0 : $urandom);
   endtask

   function automatic src_req_type random_req();
      src_req_type r;
      r.kind = $urandom_range(2, 0) == 0 ? 3'($urandom) : 3'($urandom_range(1, 0));
      if ($urandom_range(4, 0) == 0) begin
         r.cell_x = $urandom;
         r.cell_y = $urandom;
         r.time_step = $urandom;
      end else begin
         r.cell_x = $urandom_range(9, 0);
         r.cell_y = $urandom_range(9, 0);
         r.time_step = $urandom_range(300, 0);
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_values.push_back(predict_source(pending_reqs.pop_front()));
            next_wait = idle_enable ? $urandom_range(9, 0) : 0;
            if (next_wait == 0 && pending_reqs.size() != 0) begin
               // no gap: next request follows right away
               req_kind      <= pending_reqs[0].kind;
               req_cell_x    <= pending_reqs[0].cell_x;
               req_cell_y    <= pending_reqs[0].cell_y;
               req_time_step <= pending_reqs[0].time_step;
            end else begin
               req_valid <= 1'b0;
               drv_wait  <= next_wait;
            end
         end else if (!req_valid && drv_wait > 0) begin
            drv_wait <= drv_wait - 1;
         end else if (!req_valid && pending_reqs.size() != 0) begin
            req_valid     <= 1'b1;
            req_kind      <= pending_reqs[0].kind;
            req_cell_x    <= pending_reqs[0].cell_x;
            req_cell_y    <= pending_reqs[0].cell_y;
            req_time_step <= pending_reqs[0].time_step;
         end
      end
   end

   // long response hold-off counter
   always @(posedge clock) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0)
               report_mismatch("unexpected response", rsp_source_value, 32'hx);
            else if (rsp_source_value !== expected_values[0])
               report_mismatch("source_value", rsp_source_value, expected_values.pop_front());
            else
               void'(expected_values.pop_front());
         end
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
         end else if (mon_wait > 0) begin
            mon_wait <= mon_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready && idle_enable) mon_wait <= $urandom_range(9, 0);
         end
      end
   end

   initial begin
      src_req_type r;
      model_cfg = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_setting(0);
      for (int k = 0; k < 8; k++) begin
         r.kind = 3'(k);
         r.cell_x = 16'd4;
         r.cell_y = 16'd4;
         r.time_step = 32'd16;
         pending_reqs.push_back(r);
      end
      r = '{wsfs_pkg::KIND_DX, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}; pending_reqs.push_back(r);
      r = '{wsfs_pkg::KIND_DY, 16'h0, 16'h0, 32'h0};              pending_reqs.push_back(r);
      r = '{wsfs_pkg::KIND_DY, 16'h4, 16'h3, 32'hFFFF_FFFF};      pending_reqs.push_back(r);
      r = '{wsfs_pkg::KIND_DX, 16'h3, 16'h4, 32'd1};              pending_reqs.push_back(r);
      wait_drained();
      program_setting(2);
      r = '{wsfs_pkg::KIND_DX, 16'h0, 16'h0, 32'd1};       pending_reqs.push_back(r);
      r = '{wsfs_pkg::KIND_DY, 16'hFFFF, 16'h0, 32'd0};    pending_reqs.push_back(r);
      wait_drained();
      for (int phase = 0; phase < 5; phase++) begin
         program_setting(phase == 1 ? 1 : 3);
         idle_enable = (phase != 2);
         for (int n = 0; n < 210; n++) pending_reqs.push_back(random_req());
         if (phase == 3) begin
            // long response hold-off while requests keep coming
            @(posedge clock);
            hold_off <= 200;
         end
         wait_drained();
      end
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
